// ----- design/spq_pkg.sv -----
`timescale 1ns / 1ps

package spq_pkg;

  // request codes on req_type_i
  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_REMOVE = 1'b1;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic insert;
    logic remove;
  } spq_ctrl_t;

endpackage

// ----- design/sorted_priority_queue_unit.sv -----
`timescale 1ns / 1ps
// Sorted priority queue, QUEUE_DEPTH entries kept in ascending priority order.
// Command channel: a request is taken at a rising edge with start_i high and
// busy_o low. req_type_i selects insert (item_value_i, item_priority_i) or
// removal of the front entry. Equal priorities leave first in, first out.
// busy_o stays low: one request per cycle, back to back without gaps.
// Result channel: done_o is high for exactly one cycle, the cycle after the
// request, with head_value_o, head_priority_o, entry_count_o, is_empty_o,
// overflow_o and underflow_o valid in that cycle only. Throughput is one
// request per cycle; the receiver cannot stall the block.
// The state is a row of cells, one per slot; on every request each cell
// loads the new item, its left neighbor, its right neighbor or holds,
// all in the same cycle, so the rate is set by the single cell update.
// An insert into a full queue is dropped with overflow_o; a removal from an
// empty queue sets underflow_o. Empty head fields read as zero.
// Reset (rst_ni low, asynchronous) empties the queue and clears done_o;
// no clearing pass is needed.

module sorted_priority_queue_unit import spq_pkg::*; #(
  parameter int QUEUE_DEPTH    = 16,
  parameter int ITEM_WIDTH     = 32,
  parameter int PRIORITY_WIDTH = 8
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  output logic                                 busy_o,
  input  logic                                 req_type_i,
  input  logic [ITEM_WIDTH-1:0]                item_value_i,
  input  logic [PRIORITY_WIDTH-1:0]            item_priority_i,
  output logic                                 done_o,
  output logic [ITEM_WIDTH-1:0]                head_value_o,
  output logic [PRIORITY_WIDTH-1:0]            head_priority_o,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0]     entry_count_o,
  output logic                                 is_empty_o,
  output logic                                 overflow_o,
  output logic                                 underflow_o
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic          accept;
  logic          full, empty;
  spq_ctrl_t     ctrl;
  logic [CW-1:0] count_q, count_d;
  logic          done_q, ovf_q, unf_q;
  logic          ovf_d, unf_d;

  logic [QUEUE_DEPTH-1:0]    take_w;
  logic [QUEUE_DEPTH-1:0]    valid_w;
  logic [ITEM_WIDTH-1:0]     value_w [QUEUE_DEPTH];
  logic [PRIORITY_WIDTH-1:0] prio_w  [QUEUE_DEPTH];

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;
  assign full   = (count_q == CW'(QUEUE_DEPTH));
  assign empty  = (count_q == '0);

  // decode request into cell command and flags
  always_comb begin
    ctrl    = '0;
    ovf_d   = 1'b0;
    unf_d   = 1'b0;
    count_d = count_q;
    if (accept) begin
      case (req_type_i)
        REQ_INSERT: begin
          if (full) begin
            ovf_d = 1'b1;
          end else begin
            ctrl.insert = 1'b1;
            count_d     = count_q + CW'(1);
          end
        end
        REQ_REMOVE: begin
          if (empty) begin
            unf_d = 1'b1;
          end else begin
            ctrl.remove = 1'b1;
            count_d     = count_q - CW'(1);
          end
        end
        default: begin
          ctrl = '0;
        end
      endcase
    end
  end

  // row of slot cells, slot 0 is the front
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic                      p_take, p_valid, n_valid;
    logic [ITEM_WIDTH-1:0]     p_value, n_value;
    logic [PRIORITY_WIDTH-1:0] p_prio, n_prio;

    if (i == 0) begin : g_first
      assign p_take  = 1'b0;
      assign p_valid = 1'b0;
      assign p_value = '0;
      assign p_prio  = '0;
    end else begin : g_mid
      assign p_take  = take_w[i-1];
      assign p_valid = valid_w[i-1];
      assign p_value = value_w[i-1];
      assign p_prio  = prio_w[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign n_valid = 1'b0;
      assign n_value = '0;
      assign n_prio  = '0;
    end else begin : g_inner
      assign n_valid = valid_w[i+1];
      assign n_value = value_w[i+1];
      assign n_prio  = prio_w[i+1];
    end

    spq_cell #(
      .ITEM_WIDTH    (ITEM_WIDTH),
      .PRIORITY_WIDTH(PRIORITY_WIDTH)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .new_value_i (item_value_i),
      .new_prio_i  (item_priority_i),
      .prev_take_i (p_take),
      .prev_valid_i(p_valid),
      .prev_value_i(p_value),
      .prev_prio_i (p_prio),
      .next_valid_i(n_valid),
      .next_value_i(n_value),
      .next_prio_i (n_prio),
      .take_o      (take_w[i]),
      .valid_o     (valid_w[i]),
      .value_o     (value_w[i]),
      .prio_o      (prio_w[i])
    );
  end

  // count, strobe and flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
      ovf_q   <= 1'b0;
      unf_q   <= 1'b0;
    end else begin
      count_q <= count_d;
      done_q  <= accept;
      ovf_q   <= ovf_d;
      unf_q   <= unf_d;
    end
  end

  // result ports, front cell gated by its valid bit
  assign done_o          = done_q;
  assign head_value_o    = valid_w[0] ? value_w[0] : '0;
  assign head_priority_o = valid_w[0] ? prio_w[0] : '0;
  assign entry_count_o   = count_q;
  assign is_empty_o      = !valid_w[0];
  assign overflow_o      = ovf_q;
  assign underflow_o     = unf_q;

  // count never exceeds depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(QUEUE_DEPTH))
    else $error("entry count above depth");

  // count agrees with front cell occupancy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) == !valid_w[0])
    else $error("count and front slot disagree");

  // occupied cells form a contiguous run from the front
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (({1'b0, valid_w} + {{QUEUE_DEPTH{1'b0}}, 1'b1}) & {1'b0, valid_w}) == '0)
    else $error("gap in occupied cells");

  // a request cannot both overflow and underflow
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ovf_q && unf_q))
    else $error("overflow and underflow together");

  // back cell can take an item whenever the queue has room
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !full |-> take_w[QUEUE_DEPTH-1])
    else $error("back cell blocked while queue not full");

endmodule

// ----- design/spq_cell.sv -----
`timescale 1ns / 1ps

module spq_cell import spq_pkg::*; #(
  parameter int ITEM_WIDTH     = 32,
  parameter int PRIORITY_WIDTH = 8
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  spq_ctrl_t                 ctrl_i,
  input  logic [ITEM_WIDTH-1:0]     new_value_i,
  input  logic [PRIORITY_WIDTH-1:0] new_prio_i,
  // left neighbor (closer to the front)
  input  logic                      prev_take_i,
  input  logic                      prev_valid_i,
  input  logic [ITEM_WIDTH-1:0]     prev_value_i,
  input  logic [PRIORITY_WIDTH-1:0] prev_prio_i,
  // right neighbor (closer to the back)
  input  logic                      next_valid_i,
  input  logic [ITEM_WIDTH-1:0]     next_value_i,
  input  logic [PRIORITY_WIDTH-1:0] next_prio_i,
  output logic                      take_o,
  output logic                      valid_o,
  output logic [ITEM_WIDTH-1:0]     value_o,
  output logic [PRIORITY_WIDTH-1:0] prio_o
);

  logic                      valid_q, valid_d;
  logic [ITEM_WIDTH-1:0]     value_q, value_d;
  logic [PRIORITY_WIDTH-1:0] prio_q, prio_d;

  // new item belongs here or further front: free slot or strictly greater priority
  assign take_o = !valid_q || (prio_q > new_prio_i);

  // next cell contents
  always_comb begin
    valid_d = valid_q;
    value_d = value_q;
    prio_d  = prio_q;
    if (ctrl_i.insert) begin
      if (prev_take_i) begin
        valid_d = prev_valid_i;
        value_d = prev_value_i;
        prio_d  = prev_prio_i;
      end else if (take_o) begin
        valid_d = 1'b1;
        value_d = new_value_i;
        prio_d  = new_prio_i;
      end
    end else if (ctrl_i.remove) begin
      valid_d = next_valid_i;
      value_d = next_value_i;
      prio_d  = next_prio_i;
    end
  end

  // occupancy flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    prio_q  <= prio_d;
  end

  assign valid_o = valid_q;
  assign value_o = value_q;
  assign prio_o  = prio_q;

endmodule

// ----- test/sorted_priority_queue_unit_test.sv -----
`timescale 1ns / 1ps

module sorted_priority_queue_unit_test import spq_pkg::*;;

  localparam int DEPTH      = 16;
  localparam int VALUE_W    = 32;
  localparam int PRIO_W     = 8;
  localparam int COUNT_W    = $clog2(DEPTH + 1);
  localparam int RAND_ITEMS = 1980;
  localparam int CALM_ITEMS = 200;
  localparam int STALL_MAX  = 1000;

  // one request as the sender presents it
  typedef struct {
    logic               kind;
    logic [VALUE_W-1:0] value;
    logic [PRIO_W-1:0]  prio;
    bit                 drain_first;
    bit                 no_gaps;
  } request_t;

  // head report after one request
  typedef struct {
    logic [VALUE_W-1:0] head_value;
    logic [PRIO_W-1:0]  head_priority;
    logic [COUNT_W-1:0] entry_count;
    logic               is_empty;
    logic               overflow;
    logic               underflow;
  } head_report_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start_i = 1'b0;
  logic               req_type_i = REQ_INSERT;
  logic [VALUE_W-1:0] item_value_i = '0;
  logic [PRIO_W-1:0]  item_priority_i = '0;
  logic               busy_o;
  logic               done_o;
  logic [VALUE_W-1:0] head_value_o;
  logic [PRIO_W-1:0]  head_priority_o;
  logic [COUNT_W-1:0] entry_count_o;
  logic               is_empty_o;
  logic               overflow_o;
  logic               underflow_o;

  sorted_priority_queue_unit #(
    .QUEUE_DEPTH    (DEPTH),
    .ITEM_WIDTH     (VALUE_W),
    .PRIORITY_WIDTH (PRIO_W)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .req_type_i      (req_type_i),
    .item_value_i    (item_value_i),
    .item_priority_i (item_priority_i),
    .done_o          (done_o),
    .head_value_o    (head_value_o),
    .head_priority_o (head_priority_o),
    .entry_count_o   (entry_count_o),
    .is_empty_o      (is_empty_o),
    .overflow_o      (overflow_o),
    .underflow_o     (underflow_o)
  );

  always #5 clk_i = ~clk_i;

  request_t     pending_q[$];
  head_report_t head_reports_q[$];

  // shadow copy of the sorted slots
  logic [VALUE_W-1:0] shadow_values[DEPTH];
  logic [PRIO_W-1:0]  shadow_prios[DEPTH];
  int                 shadow_fill = 0;

  int  mismatches = 0;
  int  n_inserts = 0;
  int  n_removes = 0;
  int  n_overflows = 0;
  int  n_underflows = 0;
  int  n_full_hits = 0;
  int  n_results = 0;
  int  gap_left = 0;
  int  idle_cycles = 0;
  request_t presented;

  // apply one request to the shadow queue and report the new head
  function automatic head_report_t apply_request(request_t rq);
    head_report_t rep;
    int           pos;
    bit           found;
    rep = '{default: '0};
    if (rq.kind == REQ_INSERT) begin
      if (shadow_fill == DEPTH) begin
        rep.overflow = 1'b1;
        n_overflows++;
      end else begin
        // goes ahead of the first strictly greater priority, so ties stay in order
        pos = shadow_fill;
        found = 1'b0;
        for (int i = 0; i < shadow_fill; i++) begin
          if (!found && shadow_prios[i] > rq.prio) begin
            pos = i;
            found = 1'b1;
          end
        end
        for (int i = shadow_fill; i > pos; i--) begin
          shadow_values[i] = shadow_values[i-1];
          shadow_prios[i]  = shadow_prios[i-1];
        end
        shadow_values[pos] = rq.value;
        shadow_prios[pos]  = rq.prio;
        shadow_fill++;
        if (shadow_fill == DEPTH) n_full_hits++;
      end
      n_inserts++;
    end else begin
      if (shadow_fill == 0) begin
        rep.underflow = 1'b1;
        n_underflows++;
      end else begin
        for (int i = 1; i < shadow_fill; i++) begin
          shadow_values[i-1] = shadow_values[i];
          shadow_prios[i-1]  = shadow_prios[i];
        end
        shadow_fill--;
      end
      n_removes++;
    end
    if (shadow_fill == 0) begin
      rep.is_empty = 1'b1;
    end else begin
      rep.head_value    = shadow_values[0];
      rep.head_priority = shadow_prios[0];
    end
    rep.entry_count = COUNT_W'(shadow_fill);
    return rep;
  endfunction

  function automatic void check_field(string name, logic [63:0] expd, logic [63:0] got);
    if (got !== expd) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, expd, got);
      mismatches++;
    end
  endfunction

  task automatic add_request(logic kind, logic [VALUE_W-1:0] value, logic [PRIO_W-1:0] prio,
                             bit drain_first, bit no_gaps);
    request_t rq;
    rq.kind        = kind;
    rq.value       = value;
    rq.prio        = prio;
    rq.drain_first = drain_first;
    rq.no_gaps     = no_gaps;
    pending_q.push_back(rq);
  endtask

  // driver: takes the accepted item, then presents the next one or idles
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_i         <= 1'b0;
      req_type_i      <= REQ_INSERT;
      item_value_i    <= '0;
      item_priority_i <= '0;
    end else begin
      if (start_i && !busy_o) head_reports_q.push_back(apply_request(presented));
      if ((start_i && !busy_o) || !start_i) begin
        if (gap_left > 0) begin
          gap_left--;
          start_i <= 1'b0;
        end else if (pending_q.size() == 0) begin
          start_i <= 1'b0;
        end else if (pending_q[0].drain_first && head_reports_q.size() != 0) begin
          start_i <= 1'b0;
        end else if (!pending_q[0].no_gaps && $urandom_range(0, 7) == 0) begin
          gap_left = $urandom_range(1, 17) - 1;
          start_i <= 1'b0;
        end else begin
          presented = pending_q.pop_front();
          start_i         <= 1'b1;
          req_type_i      <= presented.kind;
          item_value_i    <= presented.value;
          item_priority_i <= presented.prio;
        end
      end
    end
  end

  // monitor: every strobed result against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && done_o === 1'b1) begin
      n_results++;
      if (head_reports_q.size() == 0) begin
        $display("%0t: result with none expected, expected nothing, actual count %0d",
                 $time, entry_count_o);
        mismatches++;
      end else begin
        head_report_t want;
        want = head_reports_q.pop_front();
        check_field("head_value", 64'(want.head_value), 64'(head_value_o));
        check_field("head_priority", 64'(want.head_priority), 64'(head_priority_o));
        check_field("entry_count", 64'(want.entry_count), 64'(entry_count_o));
        check_field("is_empty", 64'(want.is_empty), 64'(is_empty_o));
        check_field("overflow", 64'(want.overflow), 64'(overflow_o));
        check_field("underflow", 64'(want.underflow), 64'(underflow_o));
      end
    end
  end

  // watchdog on cycles where neither side moves anything
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start_i && !busy_o) || done_o === 1'b1) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_MAX) begin
        $display("[sorted_priority_queue_unit] ERROR");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    int           made;
    int           seg_len;
    int           insert_pct;
    int           prio_mode;
    logic         kind;
    logic [PRIO_W-1:0] prio;

    // directed: underflow, fill with extremes and ties, overflow, a few removals
    add_request(REQ_REMOVE, '1, '1, 1'b0, 1'b0);
    add_request(REQ_INSERT, 32'h0000_0000, 8'd128, 1'b0, 1'b0);
    add_request(REQ_INSERT, 32'hffff_ffff, 8'd255, 1'b0, 1'b0);
    add_request(REQ_INSERT, 32'ha5a5_a5a5, 8'd128, 1'b0, 1'b0);
    add_request(REQ_INSERT, 32'h5a5a_5a5a, 8'd0, 1'b0, 1'b0);
    add_request(REQ_INSERT, 32'h0000_0001, 8'd0, 1'b0, 1'b0);
    add_request(REQ_INSERT, 32'h8000_0000, 8'd255, 1'b0, 1'b0);
    add_request(REQ_INSERT, 32'h7fff_ffff, 8'd127, 1'b0, 1'b0);
    add_request(REQ_INSERT, 32'h0000_0002, 8'd129, 1'b0, 1'b0);
    for (int i = 0; i < 8; i++) begin
      add_request(REQ_INSERT, 32'h1000_0000 + i, 8'(1 << (i % 8)), 1'b0, 1'b0);
    end
    add_request(REQ_INSERT, 32'hdead_beef, 8'd0, 1'b0, 1'b0);
    add_request(REQ_INSERT, 32'hcafe_f00d, 8'd255, 1'b0, 1'b0);
    for (int i = 0; i < 3; i++) add_request(REQ_REMOVE, '0, '0, 1'b0, 1'b0);

    // random: segments leaning toward filling, draining or balance
    made = 0;
    while (made < RAND_ITEMS) begin
      seg_len    = $urandom_range(20, 80);
      insert_pct = 25 * $urandom_range(1, 3);
      prio_mode  = $urandom_range(0, 2);
      for (int j = 0; j < seg_len && made < RAND_ITEMS; j++) begin
        kind = ($urandom_range(0, 99) < insert_pct) ? REQ_INSERT : REQ_REMOVE;
        case (prio_mode)
          0: prio = PRIO_W'($urandom_range(0, 3));
          1: prio = PRIO_W'($urandom_range(0, 255));
          default: begin
            prio = $urandom_range(0, 1) ? PRIO_W'($urandom_range(0, 255)) :
                   ($urandom_range(0, 1) ? '0 : '1);
          end
        endcase
        add_request(kind, VALUE_W'($urandom()), prio,
                    (made == 0 || made == RAND_ITEMS / 2),
                    (made >= RAND_ITEMS - CALM_ITEMS));
        made++;
      end
    end

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_q.size() != 0 || start_i || head_reports_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);

    $display("covered %0d inserts and %0d removals, %0d results checked", n_inserts,
             n_removes, n_results);
    $display("queue filled %0d times, %0d overflows, %0d underflows", n_full_hits,
             n_overflows, n_underflows);
    if (head_reports_q.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, head_reports_q.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("[sorted_priority_queue_unit] OK");
    end else begin
      $display("[sorted_priority_queue_unit] ERROR");
    end
    $finish;
  end

endmodule
